### rtl/core/gtd_pkg.sv
// Shared types, constants and the 2-bit code decoder for the genotype track decoder.
// Used by gtd_front, gtd_div, gtd_back and genotype_track_decode_freq_top.
package gtd_pkg;

  localparam int SUM_W      = 22;
  localparam int FREQ_W     = 18;
  localparam int SAMPLES    = 4;
  localparam int QUEUE_D    = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int PADDR_W    = 3;

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 18'd131072;
  localparam logic [4:0]        DIV_STEPS = 5'd17;

  // Register map: word index taken from paddr[2].
  localparam logic REG_NO_MISSING = 1'b0;

  // Two-bit sample codes.
  localparam logic [1:0] CODE_ZERO = 2'b00;
  localparam logic [1:0] CODE_MISS = 2'b01;
  localparam logic [1:0] CODE_ONE  = 2'b10;
  localparam logic [1:0] CODE_TWO  = 2'b11;

  typedef struct packed {
    logic [1:0] val;
    logic       miss;
  } gtd_code_t;

  typedef struct packed {
    logic [1:0] dos;
    logic [1:0] hap;
    logic       dm;
    logic       hm;
  } gtd_samp_t;

  typedef struct packed {
    logic                      last;
    logic [SAMPLES-1:0]        used;
    gtd_samp_t [SAMPLES-1:0]   samp;
  } gtd_item_t;

  typedef struct packed {
    logic              is_summary;
    logic [1:0]        dosage;
    logic [1:0]        hap_count;
    logic              dosage_missing;
    logic              hap_missing;
    logic [FREQ_W-1:0] frequency;
    logic              last;
  } gtd_res_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } gtd_div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SAMP,
    ST_DIV
  } gtd_state_t;

  function automatic gtd_code_t gtd_decode(input logic [1:0] code, input logic no_missing);
    gtd_code_t r;
    r.miss = 1'b0;
    r.val  = 2'd0;
    unique case (code)
      CODE_ONE:  r.val = 2'd1;
      CODE_TWO:  r.val = 2'd2;
      CODE_MISS: r.miss = ~no_missing;
      default:   r.val = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/genotype_track_decode_freq_top.sv
// Top level of the genotype track decoder: configuration register and the front/back parts.
// Depends on gtd_pkg, gtd_front and gtd_back.
//
// Input channel (s_*): one item per byte pair of the dosage and haplotype-count tracks,
// with the mask of used samples; s_tlast marks the final byte of a marker.
// Output channel (m_*): one result per used sample, in sample order 0 to 3, then after
// the final byte a summary (m_tuser high, m_tlast high) with the Q2.16 frequency
// dosage_sum / hap_sum, saturated at 2.0 and 0 when hap_sum is zero.
// Configuration: APB register 0 (no_missing); write it only while the block is idle.
// The first result of an item passes from the queue entry through the item register (cur)
// to the output register. The output register moves one result per cycle while m_tready
// allows it; after a final byte the summary waits for the divider, which produces one
// quotient bit per cycle, or skips the division when the frequency saturates or hap_sum
// is zero.
// A two-entry queue between decode and result sequencing takes items while the output
// side is stalled, until it fills; when the receiver holds m_tready low, results wait in
// the output register and nothing is lost.
// Reset clears the sums, the queue, m_tvalid and no_missing; the output data is not reset.
module genotype_track_decode_freq_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gtd_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] dosage_byte, [15:8] hap_byte, [19:16] used_mask, [23:20] zero
  input  logic [gtd_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] dosage, [3:2] hap_count, [4] dosage_missing, [5] hap_missing, [23:6] frequency
  output logic [gtd_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] is_summary
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import gtd_pkg::*;

  logic      no_missing;
  logic      q_valid;
  logic      q_pop;
  gtd_item_t q_item;
  gtd_res_t  res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_missing <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NO_MISSING) begin
      no_missing <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_NO_MISSING) ? {31'd0, no_missing} : 32'd0;

  gtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .no_missing (no_missing),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  gtd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {res.frequency, res.hap_missing, res.dosage_missing,
                    res.hap_count, res.dosage};
  assign m_tuser = res.is_summary;
  assign m_tlast = res.last;

endmodule

### rtl/core/gtd_front.sv
// Front end: decodes the two track bytes of each item and holds them in a two-entry queue.
// Depends on gtd_pkg.
module gtd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             no_missing,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gtd_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  output logic                             q_valid,
  output gtd_pkg::gtd_item_t               q_item,
  input  logic                             q_pop
);
  import gtd_pkg::*;

  gtd_item_t  entry [QUEUE_D];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  gtd_item_t  dec;
  gtd_code_t  dcode;
  gtd_code_t  hcode;

  // The user must change no_missing only while idle, unenforced here; decoding relies on it.
  always_comb begin
    dec.last = s_tlast;
    dec.used = s_tdata[19:16];
    for (int i = 0; i < SAMPLES; i++) begin
      dcode = gtd_decode(s_tdata[2*i +: 2], no_missing);
      hcode = gtd_decode(s_tdata[8 + 2*i +: 2], no_missing);
      dec.samp[i].dos = dcode.val;
      dec.samp[i].dm  = dcode.miss;
      dec.samp[i].hap = hcode.val;
      dec.samp[i].hm  = hcode.miss;
    end
  end

  assign s_tready = (count != 2'(QUEUE_D));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_D))
    else $error("queue count exceeds its depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

### rtl/core/gtd_div.sv
// Iterative restoring divider for the Q2.16 frequency, one quotient bit per cycle.
// Depends on gtd_pkg.
module gtd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  gtd_pkg::gtd_div_req_t            req,
  output logic                             busy,
  output logic [gtd_pkg::FREQ_W-1:0]       quo
);
  import gtd_pkg::*;

  logic [SUM_W:0]   rem;
  logic [SUM_W-1:0] den_q;
  logic [4:0]       steps;
  logic [SUM_W+1:0] diff;
  logic             borrow;
  logic [SUM_W:0]   rem_keep;

  assign diff     = {1'b0, rem} - {2'b00, den_q};
  assign borrow   = diff[SUM_W+1];
  assign rem_keep = borrow ? rem : diff[SUM_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      quo   <= '0;
      steps <= '0;
    end else if (req.start) begin
      den_q <= req.den;
      rem   <= {1'b0, req.num};
      if (req.den == '0) begin
        quo <= '0;
      end else if ({1'b0, req.num} >= {req.den, 1'b0}) begin
        // Quotient is at least 2.0 when num >= 2*den.
        quo <= FREQ_MAX;
      end else begin
        quo   <= '0;
        steps <= DIV_STEPS;
        busy  <= 1'b1;
      end
    end else if (busy) begin
      quo   <= {quo[FREQ_W-2:0], ~borrow};
      rem   <= {rem_keep[SUM_W-1:0], 1'b0};
      steps <= steps - 5'd1;
      if (steps == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_steps: assert property (@(posedge clk) disable iff (rst)
    busy |-> steps != 5'd0)
    else $error("divider busy with no steps left");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> quo <= FREQ_MAX)
    else $error("frequency above saturation");
`endif

endmodule

### rtl/core/gtd_back.sv
// Back end: emits one result per used sample, keeps the running sums and the summary.
// Depends on gtd_pkg and gtd_div.
module gtd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  gtd_pkg::gtd_item_t               q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output gtd_pkg::gtd_res_t                res
);
  import gtd_pkg::*;

  gtd_state_t         state;
  gtd_state_t         state_next;
  gtd_item_t          cur;
  logic [SAMPLES-1:0] rem;
  logic [SAMPLES-1:0] rem_next;
  logic [SUM_W-1:0]   dosage_sum;
  logic [SUM_W-1:0]   dosage_sum_next;
  logic [SUM_W-1:0]   hap_sum;
  logic [SUM_W-1:0]   hap_sum_next;
  logic               out_free;
  logic               emit;
  logic               load;
  logic               finish;
  gtd_res_t           res_new;
  logic [1:0]         idx;
  gtd_samp_t          smp;
  gtd_div_req_t       div_req;
  logic               div_busy;
  logic [FREQ_W-1:0]  div_quo;
  logic [SUM_W:0]     dsum_add;
  logic [SUM_W:0]     hsum_add;

  gtd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quo  (div_quo)
  );

  assign out_free = !m_tvalid || m_tready;

  // Lowest pending sample goes out first.
  always_comb begin
    if (rem[0]) begin
      idx = 2'd0;
    end else if (rem[1]) begin
      idx = 2'd1;
    end else if (rem[2]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
  end

  assign smp      = cur.samp[idx];
  assign dsum_add = {1'b0, dosage_sum} + {{(SUM_W-1){1'b0}}, smp.dos};
  assign hsum_add = {1'b0, hap_sum} + {{(SUM_W-1){1'b0}}, smp.hap};

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    dosage_sum_next = dosage_sum;
    hap_sum_next    = hap_sum;
    emit            = 1'b0;
    load            = 1'b0;
    finish          = 1'b0;
    q_pop           = 1'b0;
    res_new         = '0;
    div_req.start   = 1'b0;
    div_req.num     = dosage_sum_next;
    div_req.den     = hap_sum_next;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          load       = 1'b1;
          state_next = ST_SAMP;
        end
      end
      ST_SAMP: begin
        if (rem == '0) begin
          finish = 1'b1;
        end else if (out_free) begin
          emit                   = 1'b1;
          res_new.dosage         = smp.dos;
          res_new.hap_count      = smp.hap;
          res_new.dosage_missing = smp.dm;
          res_new.hap_missing    = smp.hm;
          if (!smp.dm && !smp.hm) begin
            dosage_sum_next = dsum_add[SUM_W] ? SUM_MAX : dsum_add[SUM_W-1:0];
            hap_sum_next    = hsum_add[SUM_W] ? SUM_MAX : hsum_add[SUM_W-1:0];
          end
          rem_next = rem & ~(SAMPLES'(1) << idx);
          if (rem_next == '0) begin
            finish = 1'b1;
          end
        end
        if (finish) begin
          if (cur.last) begin
            div_req.start = 1'b1;
            state_next    = ST_DIV;
          end else if (q_valid) begin
            q_pop      = 1'b1;
            load       = 1'b1;
            state_next = ST_SAMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          emit               = 1'b1;
          res_new.is_summary = 1'b1;
          res_new.frequency  = div_quo;
          res_new.last       = 1'b1;
          dosage_sum_next    = '0;
          hap_sum_next       = '0;
          if (q_valid) begin
            q_pop      = 1'b1;
            load       = 1'b1;
            state_next = ST_SAMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    div_req.num = dosage_sum_next;
    div_req.den = hap_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rem        <= '0;
      dosage_sum <= '0;
      hap_sum    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      dosage_sum <= dosage_sum_next;
      hap_sum    <= hap_sum_next;
      if (load) begin
        rem <= q_item.used;
      end else begin
        rem <= rem_next;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_item;
    end
    if (emit) begin
      res <= res_new;
    end
  end

`ifndef SYNTHESIS
  a_div_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem == '0)
    else $error("summary started with samples still pending");
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    emit && state == ST_DIV |=> m_tvalid && res.is_summary && res.last)
    else $error("summary result not marked last");
`endif

endmodule
